>>> hdl/dark_box_grid_splitter_macros.svh
// assertion macros shared by the grid splitter rtl
`ifndef DARK_BOX_GRID_SPLITTER_MACROS_SVH
`define DARK_BOX_GRID_SPLITTER_MACROS_SVH
`ifndef SYNTHESIS
`define DBGS_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define DBGS_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DBGS_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define DBGS_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> hdl/dbgs_pkg.sv
`default_nettype none
package dbgs_pkg;

    localparam int MAX_SIDE   = 4096;
    localparam int MAX_CELLS  = 31;
    localparam int FIELD_W    = 13;
    localparam int SIDE_W     = $clog2(MAX_SIDE);
    localparam int CELL_W     = 5;
    localparam int CH_W       = 8;
    localparam int SUM_W      = 10;
    localparam int THR_W      = 10;
    localparam int STATUS_W   = 2;
    localparam int KIND_W     = 2;
    localparam int NUM_W      = $clog2(2 * MAX_CELLS * MAX_SIDE + MAX_CELLS + 1);
    localparam int DEN_W      = CELL_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [FIELD_W-1:0] RST_IMAGE_SIDE = FIELD_W'(4096);
    localparam logic [CELL_W-1:0]  RST_GRID_CELLS = CELL_W'(12);
    localparam logic [THR_W-1:0]   RST_THRESHOLD  = THR_W'(3 * 240);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DARK_THRESH  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_FOUND = 2'd0;
    localparam logic [STATUS_W-1:0] ST_WHOLE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DEGEN = 2'd2;

    localparam logic [KIND_W-1:0] KIND_BOX = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ROW = 2'd2;

    typedef struct packed {
        logic              frame_end;
        logic              dark_seen;
        logic [SIDE_W-1:0] min_col;
        logic [SIDE_W-1:0] max_col;
        logic [SIDE_W-1:0] min_row;
        logic [SIDE_W-1:0] max_row;
    } t_track;

    function automatic logic [FIELD_W-1:0] eff_side(input logic [FIELD_W-1:0] v);
        logic [FIELD_W-1:0] r;
        if (v == '0) begin
            r = FIELD_W'(1);
        end else if (v > FIELD_W'(MAX_SIDE)) begin
            r = FIELD_W'(MAX_SIDE);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [CELL_W-1:0] eff_cells(input logic [CELL_W-1:0] v);
        logic [CELL_W-1:0] r;
        if (v == '0) begin
            r = CELL_W'(1);
        end else if (v > CELL_W'(MAX_CELLS)) begin
            r = CELL_W'(MAX_CELLS);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hdl/dbgs_pix_if.sv
`default_nettype none
interface dbgs_pix_if;
    import dbgs_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink (input valid, red, green, blue, output ready);
endinterface
`default_nettype wire

>>> hdl/dbgs_res_if.sv
`default_nettype none
interface dbgs_res_if;
    import dbgs_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [KIND_W-1:0]   line_kind;
    logic [CELL_W-1:0]   line_index;
    logic [FIELD_W-1:0]  position;
    logic [FIELD_W-1:0]  box_left;
    logic [FIELD_W-1:0]  box_top;
    logic [FIELD_W-1:0]  box_right;
    logic [FIELD_W-1:0]  box_bottom;
    logic                last_result;

    modport source (output valid, status, line_kind, line_index, position, box_left,
                    box_top, box_right, box_bottom, last_result, input ready);
    modport sink (input valid, status, line_kind, line_index, position, box_left,
                  box_top, box_right, box_bottom, last_result, output ready);
endinterface
`default_nettype wire

>>> hdl/dbgs_tracker.sv
`default_nettype none
module dbgs_tracker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_accept,
    input  wire logic [dbgs_pkg::CH_W-1:0]    i_red,
    input  wire logic [dbgs_pkg::CH_W-1:0]    i_green,
    input  wire logic [dbgs_pkg::CH_W-1:0]    i_blue,
    input  wire logic [dbgs_pkg::FIELD_W-1:0] i_width,
    input  wire logic [dbgs_pkg::FIELD_W-1:0] i_height,
    input  wire logic [dbgs_pkg::THR_W-1:0]   i_threshold,
    input  wire logic                         i_clear,
    output dbgs_pkg::t_track                  o_track
);
    import dbgs_pkg::*;

    logic [SIDE_W-1:0]  r_col;
    logic [SIDE_W-1:0]  r_row;
    logic [SIDE_W-1:0]  r_min_col;
    logic [SIDE_W-1:0]  r_max_col;
    logic [SIDE_W-1:0]  r_min_row;
    logic [SIDE_W-1:0]  r_max_row;
    logic               r_dark_seen;
    logic [SUM_W-1:0]   sum;
    logic               dark;
    logic [FIELD_W-1:0] col_inc;
    logic [FIELD_W-1:0] row_inc;
    logic               row_end;
    logic               frame_end;

    assign sum       = SUM_W'(i_red) + SUM_W'(i_green) + SUM_W'(i_blue);
    assign dark      = sum < i_threshold;
    assign col_inc   = FIELD_W'(r_col) + FIELD_W'(1);
    assign row_inc   = FIELD_W'(r_row) + FIELD_W'(1);
    // a column at or past the current width also ends the line; a row at or past the height ends the frame
    assign row_end   = col_inc >= i_width;
    assign frame_end = row_end && (row_inc >= i_height);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_dark_seen <= 1'b0;
        end else if (i_clear) begin
            r_dark_seen <= 1'b0;
        end else if (i_accept) begin
            if (dark) begin
                r_dark_seen <= 1'b1;
            end
            if (row_end) begin
                r_col <= '0;
                if (frame_end) begin
                    r_row <= '0;
                end else begin
                    r_row <= row_inc[SIDE_W-1:0];
                end
            end else begin
                r_col <= col_inc[SIDE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && dark) begin
            if (!r_dark_seen || r_col < r_min_col) begin
                r_min_col <= r_col;
            end
            if (!r_dark_seen || r_col > r_max_col) begin
                r_max_col <= r_col;
            end
            if (!r_dark_seen || r_row < r_min_row) begin
                r_min_row <= r_row;
            end
            if (!r_dark_seen || r_row > r_max_row) begin
                r_max_row <= r_row;
            end
        end
    end

    assign o_track.frame_end = frame_end;
    assign o_track.dark_seen = r_dark_seen;
    assign o_track.min_col   = r_min_col;
    assign o_track.max_col   = r_max_col;
    assign o_track.min_row   = r_min_row;
    assign o_track.max_row   = r_max_row;
endmodule
`default_nettype wire

>>> hdl/dbgs_div.sv
`default_nettype none
`include "dark_box_grid_splitter_macros.svh"
module dbgs_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [dbgs_pkg::NUM_W-1:0] i_dividend,
    input  wire logic [dbgs_pkg::DEN_W-1:0] i_divisor,
    output logic                            o_done,
    output logic [dbgs_pkg::NUM_W-1:0]      o_quotient
);
    import dbgs_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_div;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;
    logic [DEN_W-1:0] n_rem;

    // restoring division, one quotient bit per cycle, msb first
    assign trial = {r_rem, r_quo[NUM_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign fits  = trial >= {1'b0, r_div};
    assign n_rem = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], fits};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    `DBGS_NEXT(a_div_start_busy, i_clk, i_rst_n, i_start, r_busy, "divider did not start")
    `DBGS_IMPLIES(a_div_no_restart, i_clk, i_rst_n, r_busy, !i_start, "divider restarted while busy")
    `DBGS_NEXT(a_div_last_step, i_clk, i_rst_n, r_busy && (r_cnt == '0), r_done && !r_busy, "divider missed its done")
    `DBGS_IMPLIES(a_div_done_idle, i_clk, i_rst_n, r_done, !r_busy, "divider done while busy")
endmodule
`default_nettype wire

>>> hdl/dbgs_seq.sv
`default_nettype none
`include "dark_box_grid_splitter_macros.svh"
module dbgs_seq (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    dbgs_pix_if.sink                          i_pix,
    dbgs_res_if.source                        o_res,
    input  wire dbgs_pkg::t_track             i_track,
    input  wire logic [dbgs_pkg::FIELD_W-1:0] i_width,
    input  wire logic [dbgs_pkg::FIELD_W-1:0] i_height,
    input  wire logic [dbgs_pkg::CELL_W-1:0]  i_grid_cols,
    input  wire logic [dbgs_pkg::CELL_W-1:0]  i_grid_rows,
    output logic                              o_accept,
    output logic                              o_clear,
    output logic                              o_div_start,
    output logic [dbgs_pkg::NUM_W-1:0]        o_dividend,
    output logic [dbgs_pkg::DEN_W-1:0]        o_divisor,
    input  wire logic                         i_div_done,
    input  wire logic [dbgs_pkg::NUM_W-1:0]   i_quotient
);
    import dbgs_pkg::*;

    localparam logic [2:0] S_PIX   = 3'd0;
    localparam logic [2:0] S_BOX   = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]          r_state;
    logic                r_axis;
    logic [CELL_W-1:0]   r_idx;
    logic [CELL_W-1:0]   r_cells;
    logic [NUM_W-1:0]    r_num;
    logic                r_ovalid;
    logic [STATUS_W-1:0] r_status;
    logic [KIND_W-1:0]   r_kind;
    logic [CELL_W-1:0]   r_lidx;
    logic [FIELD_W-1:0]  r_pos;
    logic [FIELD_W-1:0]  r_left;
    logic [FIELD_W-1:0]  r_top;
    logic [FIELD_W-1:0]  r_right;
    logic [FIELD_W-1:0]  r_bottom;
    logic                r_last;

    logic                out_free;
    logic                accept;
    logic                load_box;
    logic                load_bnd;
    logic                axis_done;
    logic [FIELD_W-1:0]  min_col_inc;
    logic [FIELD_W-1:0]  min_row_inc;
    logic [FIELD_W-1:0]  b_left;
    logic [FIELD_W-1:0]  b_top;
    logic [FIELD_W-1:0]  b_right;
    logic [FIELD_W-1:0]  b_bottom;
    logic                degen;
    logic [FIELD_W-1:0]  span;
    logic [NUM_W-1:0]    span2;
    logic [FIELD_W-1:0]  axis_start;
    logic [CELL_W-1:0]   axis_cells;

    assign out_free = !r_ovalid || o_res.ready;
    assign accept   = i_pix.valid && (r_state == S_PIX);
    assign load_box = (r_state == S_BOX) && out_free;
    assign load_bnd = (r_state == S_EMIT) && out_free;
    assign axis_done = r_idx == r_cells;

    // content box, inset by one at left and top where the frame allows; whole frame when nothing was dark
    always_comb begin
        min_col_inc = FIELD_W'(i_track.min_col) + FIELD_W'(1);
        min_row_inc = FIELD_W'(i_track.min_row) + FIELD_W'(1);
        if (!i_track.dark_seen) begin
            b_left   = '0;
            b_top    = '0;
            b_right  = i_width;
            b_bottom = i_height;
        end else begin
            b_left   = (min_col_inc < i_width) ? min_col_inc : FIELD_W'(i_track.min_col);
            b_top    = (min_row_inc < i_height) ? min_row_inc : FIELD_W'(i_track.min_row);
            b_right  = (i_track.max_col != '0) ? FIELD_W'(i_track.max_col) : FIELD_W'(1);
            b_bottom = (i_track.max_row != '0) ? FIELD_W'(i_track.max_row) : FIELD_W'(1);
        end
        degen = (b_right <= b_left) || (b_bottom <= b_top);
    end

    // numerator runs as 2*i*span + cells, divided by 2*cells for half-up rounding
    assign span       = r_axis ? (r_bottom - r_top) : (r_right - r_left);
    assign span2      = NUM_W'({span, 1'b0});
    assign axis_start = r_axis ? r_top : r_left;
    assign axis_cells = r_axis ? i_grid_rows : i_grid_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_PIX;
            r_axis   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (load_box || load_bnd) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_PIX: begin
                    if (accept && i_track.frame_end) begin
                        r_state <= S_BOX;
                    end
                end
                S_BOX: begin
                    if (out_free) begin
                        r_axis  <= 1'b0;
                        r_state <= degen ? S_PIX : S_START;
                    end
                end
                S_START: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (i_div_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        if (!axis_done) begin
                            r_state <= S_DIV;
                        end else if (!r_axis) begin
                            r_axis  <= 1'b1;
                            r_state <= S_START;
                        end else begin
                            r_state <= S_PIX;
                        end
                    end
                end
                default: begin
                    r_state <= S_PIX;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_START) begin
            r_cells <= axis_cells;
            r_idx   <= CELL_W'(1);
            r_num   <= NUM_W'(axis_cells) + span2;
        end else if (load_bnd && !axis_done) begin
            r_idx <= r_idx + CELL_W'(1);
            r_num <= r_num + span2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_box) begin
            if (degen) begin
                r_status <= ST_DEGEN;
            end else begin
                r_status <= i_track.dark_seen ? ST_FOUND : ST_WHOLE;
            end
            r_kind   <= KIND_BOX;
            r_lidx   <= '0;
            r_pos    <= '0;
            r_last   <= degen;
            r_left   <= b_left;
            r_top    <= b_top;
            r_right  <= b_right;
            r_bottom <= b_bottom;
        end else if (load_bnd) begin
            r_kind <= r_axis ? KIND_ROW : KIND_COL;
            r_lidx <= r_idx;
            r_pos  <= axis_start + i_quotient[FIELD_W-1:0];
            r_last <= r_axis && axis_done;
        end
    end

    assign i_pix.ready       = (r_state == S_PIX);
    assign o_accept          = accept;
    assign o_clear           = load_box;
    assign o_div_start       = (r_state == S_DIV);
    assign o_dividend        = r_num;
    assign o_divisor         = {r_cells, 1'b0};

    assign o_res.valid       = r_ovalid;
    assign o_res.status      = r_status;
    assign o_res.line_kind   = r_kind;
    assign o_res.line_index  = r_lidx;
    assign o_res.position    = r_pos;
    assign o_res.box_left    = r_left;
    assign o_res.box_top     = r_top;
    assign o_res.box_right   = r_right;
    assign o_res.box_bottom  = r_bottom;
    assign o_res.last_result = r_last;

    `DBGS_NEXT(a_seq_wait_emit, i_clk, i_rst_n, (r_state == S_WAIT) && i_div_done, r_state == S_EMIT, "quotient not taken")
    `DBGS_IMPLIES(a_seq_idx_range, i_clk, i_rst_n, (r_state == S_DIV) || (r_state == S_WAIT) || (r_state == S_EMIT), (r_idx != '0) && (r_idx <= r_cells), "boundary index out of range")
    `DBGS_IMPLIES(a_seq_col_in_box, i_clk, i_rst_n, r_ovalid && (r_kind == KIND_COL), (r_pos >= r_left) && (r_pos <= r_right), "column boundary outside box")
    `DBGS_IMPLIES(a_seq_last_kind, i_clk, i_rst_n, r_ovalid && r_last, (r_kind == KIND_ROW) || (r_status == ST_DEGEN), "frame closed on wrong result")
endmodule
`default_nettype wire

>>> hdl/dark_box_grid_splitter.sv
`default_nettype none
// Dark-pixel content box with an even grid split. Pixels enter in raster order, one transaction
// per clock while the frame is running; a pixel is dark when red+green+blue is below the
// threshold. On the last pixel of a frame the block stops taking pixels and emits the box
// result (inset by one at left and top, whole frame when nothing was dark), then column
// boundaries 1..grid_cols and row boundaries 1..grid_rows, last_result on the final one.
// Each boundary goes through one shared 18-bit restoring divider at one quotient bit per
// cycle; a frame end holds pixel input until the last result of the frame is taken into the
// output register, and any output stall lengthens the hold. A degenerate box gives only the
// box result, with last_result set. Registers may change mid-frame and act at once, but
// leave them alone while frame-end results are still going out.
module dark_box_grid_splitter (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [dbgs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [dbgs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    dbgs_pix_if.sink                             i_pix,
    dbgs_res_if.source                           o_res
);
    import dbgs_pkg::*;

    logic [FIELD_W-1:0] r_image_width;
    logic [FIELD_W-1:0] r_image_height;
    logic [CELL_W-1:0]  r_grid_cols;
    logic [CELL_W-1:0]  r_grid_rows;
    logic [THR_W-1:0]   r_dark_threshold;

    logic [FIELD_W-1:0] eff_width;
    logic [FIELD_W-1:0] eff_height;
    logic [CELL_W-1:0]  eff_cols;
    logic [CELL_W-1:0]  eff_rows;
    t_track             track;
    logic               accept;
    logic               clear;
    logic               div_start;
    logic               div_done;
    logic [NUM_W-1:0]   dividend;
    logic [DEN_W-1:0]   divisor;
    logic [NUM_W-1:0]   quotient;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width    <= RST_IMAGE_SIDE;
            r_image_height   <= RST_IMAGE_SIDE;
            r_grid_cols      <= RST_GRID_CELLS;
            r_grid_rows      <= RST_GRID_CELLS;
            r_dark_threshold <= RST_THRESHOLD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_IMAGE_WIDTH:  r_image_width    <= i_cfg_data[FIELD_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height   <= i_cfg_data[FIELD_W-1:0];
                REG_GRID_COLS:    r_grid_cols      <= i_cfg_data[CELL_W-1:0];
                REG_GRID_ROWS:    r_grid_rows      <= i_cfg_data[CELL_W-1:0];
                REG_DARK_THRESH:  r_dark_threshold <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // zero acts as one, oversize clamps to the limit
    assign eff_width  = eff_side(r_image_width);
    assign eff_height = eff_side(r_image_height);
    assign eff_cols   = eff_cells(r_grid_cols);
    assign eff_rows   = eff_cells(r_grid_rows);

    dbgs_tracker u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_red       (i_pix.red),
        .i_green     (i_pix.green),
        .i_blue      (i_pix.blue),
        .i_width     (eff_width),
        .i_height    (eff_height),
        .i_threshold (r_dark_threshold),
        .i_clear     (clear),
        .o_track     (track)
    );

    dbgs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    dbgs_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (i_pix),
        .o_res       (o_res),
        .i_track     (track),
        .i_width     (eff_width),
        .i_height    (eff_height),
        .i_grid_cols (eff_cols),
        .i_grid_rows (eff_rows),
        .o_accept    (accept),
        .o_clear     (clear),
        .o_div_start (div_start),
        .o_dividend  (dividend),
        .o_divisor   (divisor),
        .i_div_done  (div_done),
        .i_quotient  (quotient)
    );
endmodule
`default_nettype wire
